[hw/rtl/assert_macros.svh]
// Assertion macros used by the RTL of the sorted list store.
// Needs nothing else; simulation builds get the checks, SYNTH builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define SLST_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define SLST_ASSERT_IMPLY(lbl, clk, rst, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

`else

`define SLST_ASSERT(lbl, clk, rst, prop, msg)

`define SLST_ASSERT_IMPLY(lbl, clk, rst, cond, prop, msg)

`endif

`endif

[hw/rtl/slst_pkg.sv]
// Package of the sorted list store: field widths, item kinds, result codes and states.
// Depends on nothing.
`timescale 1ns / 1ps

package slst_pkg;

  localparam int DATA_W  = 32;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 2;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ENTRY = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_PUT,
    S_DEL,
    S_READ,
    S_RESP
  } state_t;

endpackage

[hw/rtl/slst_ram.sv]
// Entry memory of the sorted list store: one write port, one read port, registered read data.
// Depends on slst_pkg for the data width.
`timescale 1ns / 1ps

module slst_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [slst_pkg::DATA_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [slst_pkg::DATA_W-1:0] rd_data
);
  import slst_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/sorted_list_store_core.sv]
// Channel  Handshake                Word
// input    in_valid / in_stall      kind, value
// output   out_valid / out_stall    status, entry_value, position, held_count, last
//
// Insert walks down from the top entry to its slot and delete walks every held entry through
// the memory read port, one entry per cycle; a full insert, an empty readout or an unused
// kind goes straight to its status word.
// A readout delivers one word per cycle when unstalled.
// Reset clears the count and the control state; the memory itself is never cleared.
// A stalled output holds the readout walk and the final status word; one item is worked on
// at a time.
// Depends on slst_pkg, slst_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sorted_list_store_core #(
  parameter int CAPACITY = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [slst_pkg::KIND_W-1:0]        kind,
  input  logic signed [slst_pkg::DATA_W-1:0] value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [slst_pkg::STAT_W-1:0]        status,
  output logic signed [slst_pkg::DATA_W-1:0] entry_value,
  output logic [slst_pkg::POS_W-1:0]         position,
  output logic [slst_pkg::COUNT_W-1:0]       held_count,
  output logic                               last
);
  import slst_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [COUNT_W-1:0] CAP_C = COUNT_W'(CAPACITY);

  state_t state, state_next;

  logic [COUNT_W-1:0]       count, count_next;
  logic [COUNT_W-1:0]       scan, scan_next;
  logic [COUNT_W-1:0]       scan_m1;
  logic [COUNT_W-1:0]       wcnt, wcnt_next;
  logic                     rd_valid, rd_valid_next;
  logic [AW-1:0]            rd_idx, rd_idx_next;
  logic signed [DATA_W-1:0] val_reg, val_reg_next;
  logic [AW-1:0]            ins_pos, ins_pos_next;
  logic [STAT_W-1:0]        res_status, res_status_next;
  logic [POS_W-1:0]         res_pos, res_pos_next;
  logic [COUNT_W-1:0]       res_count, res_count_next;

  logic                     out_valid_next;
  logic                     out_load;
  logic [STAT_W-1:0]        status_next;
  logic signed [DATA_W-1:0] entry_value_next;
  logic [POS_W-1:0]         position_next;
  logic [COUNT_W-1:0]       held_count_next;
  logic                     last_next;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;

  logic accept;
  logic out_free;
  logic ge;
  logic ins_stop;
  logic move;
  logic scan_done;

  slst_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && (state == S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign ge        = $signed(rd_data) >= val_reg;
  assign ins_stop  = rd_valid && (!ge || (rd_idx == '0));
  assign move      = rd_valid && out_free;
  assign scan_m1   = scan - COUNT_W'(1);
  assign scan_done = (scan == count) && !rd_valid;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_INSERT: begin
              if (count >= CAP_C) begin
                state_next = S_RESP;
              end else if (count == '0) begin
                state_next = S_PUT;
              end else begin
                state_next = S_INS;
              end
            end
            KIND_DELETE: state_next = S_DEL;
            KIND_READ: begin
              state_next = (count == '0) ? S_RESP : S_READ;
            end
            default: state_next = S_RESP;
          endcase
        end
      end
      S_INS: begin
        if (ins_stop) begin
          state_next = S_PUT;
        end
      end
      S_PUT: state_next = S_RESP;
      S_DEL: begin
        if (scan_done) begin
          state_next = S_RESP;
        end
      end
      S_READ: begin
        if (scan_done) begin
          state_next = S_IDLE;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    count_next      = count;
    scan_next       = scan;
    wcnt_next       = wcnt;
    rd_valid_next   = rd_valid;
    val_reg_next    = val_reg;
    ins_pos_next    = ins_pos;
    res_status_next = res_status;
    res_pos_next    = res_pos;
    res_count_next  = res_count;
    rd_en           = 1'b0;
    rd_addr         = scan[AW-1:0];
    wr_en           = 1'b0;
    wr_addr         = rd_idx;
    wr_data         = rd_data;
    out_load         = 1'b0;
    status_next      = STAT_DONE;
    entry_value_next = '0;
    position_next    = '0;
    held_count_next  = count;
    last_next        = 1'b1;

    case (state)
      S_IDLE: begin
        rd_valid_next = 1'b0;
        if (accept) begin
          val_reg_next    = value;
          scan_next       = (kind == KIND_INSERT) ? count : '0;
          wcnt_next       = '0;
          ins_pos_next    = '0;
          res_pos_next    = '0;
          res_count_next  = count;
          case (kind)
            KIND_INSERT: res_status_next = STAT_FULL;
            KIND_READ: begin
              res_status_next = STAT_EMPTY;
              res_count_next  = '0;
            end
            default: res_status_next = STAT_DONE;
          endcase
        end
      end
      S_INS: begin
        if (rd_valid) begin
          if (ge) begin
            wr_en        = 1'b1;
            wr_addr      = rd_idx + AW'(1);
            wr_data      = rd_data;
            ins_pos_next = '0;
          end else begin
            ins_pos_next = rd_idx + AW'(1);
          end
        end
        rd_en   = (scan != '0) && !ins_stop;
        rd_addr = scan_m1[AW-1:0];
        if (rd_en) begin
          scan_next = scan_m1;
        end
        rd_valid_next = rd_en;
      end
      S_PUT: begin
        wr_en           = 1'b1;
        wr_addr         = ins_pos;
        wr_data         = val_reg;
        count_next      = count + COUNT_W'(1);
        res_status_next = STAT_DONE;
        res_pos_next    = POS_W'(ins_pos);
        res_count_next  = count + COUNT_W'(1);
      end
      S_DEL: begin
        if (rd_valid && !rd_data[0]) begin
          wr_en     = 1'b1;
          wr_addr   = wcnt[AW-1:0];
          wr_data   = rd_data;
          wcnt_next = wcnt + COUNT_W'(1);
        end
        rd_en   = (scan < count);
        rd_addr = scan[AW-1:0];
        if (rd_en) begin
          scan_next = scan + COUNT_W'(1);
        end
        rd_valid_next = rd_en;
        if (scan_done) begin
          count_next      = wcnt;
          res_status_next = STAT_DONE;
          res_pos_next    = '0;
          res_count_next  = wcnt;
        end
      end
      S_READ: begin
        if (move) begin
          out_load         = 1'b1;
          status_next      = STAT_ENTRY;
          entry_value_next = rd_data;
          position_next    = POS_W'(rd_idx);
          held_count_next  = count;
          last_next        = ((COUNT_W'(rd_idx) + COUNT_W'(1)) == count);
        end
        rd_en   = (scan < count) && (!rd_valid || move);
        rd_addr = scan[AW-1:0];
        if (rd_en) begin
          scan_next = scan + COUNT_W'(1);
        end
        rd_valid_next = rd_en || (rd_valid && !move);
      end
      S_RESP: begin
        if (out_free) begin
          out_load        = 1'b1;
          status_next     = res_status;
          position_next   = res_pos;
          held_count_next = res_count;
        end
      end
      default: begin
        rd_valid_next = 1'b0;
      end
    endcase
  end

  assign rd_idx_next    = rd_en ? rd_addr : rd_idx;
  assign out_valid_next = out_load || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rd_valid  <= rd_valid_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    scan       <= scan_next;
    wcnt       <= wcnt_next;
    rd_idx     <= rd_idx_next;
    val_reg    <= val_reg_next;
    ins_pos    <= ins_pos_next;
    res_status <= res_status_next;
    res_pos    <= res_pos_next;
    res_count  <= res_count_next;
    if (out_load) begin
      status      <= status_next;
      entry_value <= entry_value_next;
      position    <= position_next;
      held_count  <= held_count_next;
      last        <= last_next;
    end
  end

  `SLST_ASSERT(a_count_cap, clk, rst, count <= CAP_C, "Held count exceeds the capacity.")
  `SLST_ASSERT_IMPLY(a_entry_pos, clk, rst, out_valid && (status == STAT_ENTRY), COUNT_W'(position) < held_count, "List entry position is not below the held count.")
  `SLST_ASSERT_IMPLY(a_rd_state, clk, rst, rd_valid, (state == S_INS) || (state == S_DEL) || (state == S_READ), "Read data is pending outside a memory walk.")
  `SLST_ASSERT_IMPLY(a_read_nowrite, clk, rst, state == S_READ, !wr_en, "Memory written during a readout.")

endmodule
